// File: src/isont_pkg.sv
// ----------------------------------------------------------------------------
// isont_pkg
// Shared types and constants of the ISO 9660 / Joliet name translator.
// ----------------------------------------------------------------------------
`default_nettype none

package isont_pkg;

  localparam logic [7:0] MAX_NAME_LEN = 8'd255;
  localparam int         MAX_RESULTS  = 5;
  localparam int         RES_IDX_W    = $clog2(MAX_RESULTS);

  localparam logic [7:0] CH_QMARK   = 8'h3F;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_DIFF  = 8'h20;

  localparam logic [15:0] UTF8_TWO_MIN   = 16'h0080;
  localparam logic [15:0] UTF8_THREE_MIN = 16'h0800;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  typedef enum logic [2:0] {
    REG_UCS_LEVEL     = 3'd0,
    REG_UTF8_OUTPUT   = 3'd1,
    REG_KEEP_ORIGINAL = 3'd2,
    REG_CASE_FOLD     = 3'd3,
    REG_ASSOC_MARKER  = 3'd4
  } reg_index_t;

  localparam logic [1:0] UCS_LEVEL_RST     = 2'd0;
  localparam logic       UTF8_OUTPUT_RST   = 1'b1;
  localparam logic       KEEP_ORIGINAL_RST = 1'b0;
  localparam logic       CASE_FOLD_RST     = 1'b0;
  localparam logic [7:0] ASSOC_MARKER_RST  = 8'd61;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [7:0] name_length;
    logic       end_of_name;
  } result_t;

endpackage

`default_nettype wire

// File: src/isont_in_if.sv
// ----------------------------------------------------------------------------
// isont_in_if
// Input channel: one raw name byte per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface isont_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] name_byte;
  logic       first_byte;
  logic       last_byte;
  logic       associated;

  modport source (output valid, name_byte, first_byte, last_byte, associated, input ready);
  modport sink   (input valid, name_byte, first_byte, last_byte, associated, output ready);
endinterface

`default_nettype wire

// File: src/isont_out_if.sv
// ----------------------------------------------------------------------------
// isont_out_if
// Output channel: one translated byte or the final length per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface isont_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic [7:0] name_length;
  logic       end_of_name;
  logic       run_last;

  modport source (output valid, out_byte, byte_valid, name_length, end_of_name, run_last,
                  input ready);
  modport sink   (input valid, out_byte, byte_valid, name_length, end_of_name, run_last,
                  output ready);
endinterface

`default_nettype wire

// File: src/iso9660_name_translate_top.sv
// ----------------------------------------------------------------------------
// iso9660_name_translate_top
// Translates ISO 9660 / Joliet name bytes into output name bytes and length.
// ----------------------------------------------------------------------------
// the first result of an input transaction is shown in the cycle after it is accepted
// results are given one per cycle, while name_out is ready, from a five-entry result
//   register; a new input is taken once no result is left or as the last one is taken
// synchronous active-high reset clears name state and pending results and sets the
//   configuration registers to their defaults
`default_nettype none

module iso9660_name_translate_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  isont_in_if.sink                               name_in,
  isont_out_if.source                            name_out,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [isont_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [isont_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [isont_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                   pready
);

  // configuration registers
  logic [1:0] ucs_level;
  logic       utf8_output;
  logic       keep_original;
  logic       case_fold;
  logic [7:0] assoc_marker;

  // name state
  logic [7:0] pending_high, pending_high_next;
  logic       pending_valid, pending_valid_next;
  logic [7:0] written_count, written_count_next;
  logic [7:0] previous_out, previous_out_next;
  logic       stopped, stopped_next;

  // result register
  isont_pkg::result_t                   results [isont_pkg::MAX_RESULTS];
  isont_pkg::result_t                   results_next [isont_pkg::MAX_RESULTS];
  logic [isont_pkg::RES_IDX_W-1:0]      rd_idx;
  logic [isont_pkg::RES_IDX_W-1:0]      remaining;
  logic [isont_pkg::RES_IDX_W-1:0]      res_count;

  logic                                 in_fire;
  logic                                 out_fire;
  logic                                 cfg_write;
  isont_pkg::reg_index_t                reg_idx;

  assign reg_idx   = isont_pkg::reg_index_t'(paddr[4:2]);
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ucs_level     <= isont_pkg::UCS_LEVEL_RST;
      utf8_output   <= isont_pkg::UTF8_OUTPUT_RST;
      keep_original <= isont_pkg::KEEP_ORIGINAL_RST;
      case_fold     <= isont_pkg::CASE_FOLD_RST;
      assoc_marker  <= isont_pkg::ASSOC_MARKER_RST;
    end else if (cfg_write) begin
      unique case (reg_idx)
        isont_pkg::REG_UCS_LEVEL:     ucs_level     <= pwdata[1:0];
        isont_pkg::REG_UTF8_OUTPUT:   utf8_output   <= pwdata[0];
        isont_pkg::REG_KEEP_ORIGINAL: keep_original <= pwdata[0];
        isont_pkg::REG_CASE_FOLD:     case_fold     <= pwdata[0];
        isont_pkg::REG_ASSOC_MARKER:  assoc_marker  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      isont_pkg::REG_UCS_LEVEL:     prdata = {30'd0, ucs_level};
      isont_pkg::REG_UTF8_OUTPUT:   prdata = {31'd0, utf8_output};
      isont_pkg::REG_KEEP_ORIGINAL: prdata = {31'd0, keep_original};
      isont_pkg::REG_CASE_FOLD:     prdata = {31'd0, case_fold};
      isont_pkg::REG_ASSOC_MARKER:  prdata = {24'd0, assoc_marker};
      default:                      prdata = '0;
    endcase
  end

  // handshake
  assign name_out.valid = (remaining != '0);
  assign out_fire       = name_out.valid & name_out.ready;
  assign name_in.ready  = (remaining == '0) ||
                          ((remaining == isont_pkg::RES_IDX_W'(1)) && name_out.ready);
  assign in_fire        = name_in.valid & name_in.ready;

  assign name_out.out_byte    = results[rd_idx].out_byte;
  assign name_out.byte_valid  = results[rd_idx].byte_valid;
  assign name_out.name_length = results[rd_idx].name_length;
  assign name_out.end_of_name = results[rd_idx].end_of_name;
  assign name_out.run_last    = (remaining == isont_pkg::RES_IDX_W'(1));

  // translation of one input byte
  always_comb begin
    logic [7:0]  ph;
    logic        pv;
    logic [7:0]  wc;
    logic [7:0]  po;
    logic        st;
    logic [15:0] c;
    logic        do_put;
    logic        utf;
    logic [1:0]  need;
    logic [7:0]  cb [3];
    logic [1:0]  cn;
    logic [isont_pkg::RES_IDX_W-1:0] n;

    ph = name_in.first_byte ? 8'd0 : pending_high;
    pv = name_in.first_byte ? 1'b0 : pending_valid;
    wc = name_in.first_byte ? 8'd0 : written_count;
    po = name_in.first_byte ? 8'd0 : previous_out;
    st = name_in.first_byte ? 1'b0 : stopped;
    c      = '0;
    do_put = 1'b0;
    utf    = (ucs_level != 2'd0) && utf8_output;
    need   = 2'd1;
    cb[0]  = '0;
    cb[1]  = '0;
    cb[2]  = '0;
    cn     = 2'd0;
    n      = '0;
    for (int i = 0; i < isont_pkg::MAX_RESULTS; i++) begin
      results_next[i] = '0;
    end

    if (name_in.first_byte && name_in.associated) begin
      results_next[n].out_byte   = assoc_marker;
      results_next[n].byte_valid = 1'b1;
      n  = n + isont_pkg::RES_IDX_W'(1);
      wc = wc + 8'd1;
      po = assoc_marker;
    end

    if (!st) begin
      priority if (ucs_level == 2'd0) begin
        pv     = 1'b0;
        c      = {8'd0, name_in.name_byte};
        do_put = 1'b1;
      end else if (pv) begin
        pv = 1'b0;
        if (utf8_output) begin
          c = {ph, name_in.name_byte};
        end else if (ph != 8'd0) begin
          c = {8'd0, isont_pkg::CH_QMARK};
        end else begin
          c = {8'd0, name_in.name_byte};
        end
        do_put = 1'b1;
      end else if (name_in.last_byte) begin
        c      = {8'd0, name_in.name_byte};
        do_put = 1'b1;
      end else begin
        ph = name_in.name_byte;
        pv = 1'b1;
      end
    end

    if (do_put) begin
      if (case_fold && (ucs_level == 2'd0) &&
          (c >= {8'd0, isont_pkg::CH_UPPER_A}) && (c <= {8'd0, isont_pkg::CH_UPPER_Z})) begin
        c = c + {8'd0, isont_pkg::CASE_DIFF};
      end else if (!keep_original && (c == {8'd0, isont_pkg::CH_SEMI})) begin
        // version suffix ends the name, trailing dot leaves the length
        if ((wc != 8'd0) && (po == isont_pkg::CH_DOT)) begin
          wc = wc - 8'd1;
        end
        st     = 1'b1;
        do_put = 1'b0;
      end
    end

    if (do_put) begin
      if (!utf || (c < isont_pkg::UTF8_TWO_MIN)) begin
        need = 2'd1;
      end else if (c < isont_pkg::UTF8_THREE_MIN) begin
        need = 2'd2;
      end else begin
        need = 2'd3;
      end
      if (({1'b0, wc} + {7'd0, need}) > {1'b0, isont_pkg::MAX_NAME_LEN}) begin
        if (wc < isont_pkg::MAX_NAME_LEN) begin
          cb[0] = isont_pkg::CH_QMARK;
          cn    = 2'd1;
        end
        st = 1'b1;
      end else if (need == 2'd1) begin
        cb[0] = c[7:0];
        cn    = 2'd1;
      end else if (need == 2'd2) begin
        cb[0] = {3'b110, c[10:6]};
        cb[1] = {2'b10, c[5:0]};
        cn    = 2'd2;
      end else begin
        cb[0] = {4'b1110, c[15:12]};
        cb[1] = {2'b10, c[11:6]};
        cb[2] = {2'b10, c[5:0]};
        cn    = 2'd3;
      end
    end

    for (int i = 0; i < 3; i++) begin
      if (2'(i) < cn) begin
        results_next[n].out_byte   = cb[i];
        results_next[n].byte_valid = 1'b1;
        n = n + isont_pkg::RES_IDX_W'(1);
      end
    end
    if (cn != 2'd0) begin
      wc = wc + {6'd0, cn};
      po = cb[cn - 2'd1];
    end

    if (name_in.last_byte) begin
      results_next[n].name_length = wc;
      results_next[n].end_of_name = 1'b1;
      n  = n + isont_pkg::RES_IDX_W'(1);
      pv = 1'b0;
      st = 1'b1;
    end

    pending_high_next  = ph;
    pending_valid_next = pv;
    written_count_next = wc;
    previous_out_next  = po;
    stopped_next       = st;
    res_count          = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_high  <= '0;
      pending_valid <= 1'b0;
      written_count <= '0;
      previous_out  <= '0;
      stopped       <= 1'b0;
      rd_idx        <= '0;
      remaining     <= '0;
    end else if (in_fire) begin
      pending_high  <= pending_high_next;
      pending_valid <= pending_valid_next;
      written_count <= written_count_next;
      previous_out  <= previous_out_next;
      stopped       <= stopped_next;
      rd_idx        <= '0;
      remaining     <= res_count;
    end else if (out_fire) begin
      rd_idx    <= rd_idx + isont_pkg::RES_IDX_W'(1);
      remaining <= remaining - isont_pkg::RES_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < isont_pkg::MAX_RESULTS; i++) begin
        results[i] <= results_next[i];
      end
    end
  end

endmodule

`default_nettype wire

// File: src/isont_checker.sv
// ----------------------------------------------------------------------------
// isont_checker
// Port-level checks of the name translator output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module isont_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       byte_valid,
  input wire logic [7:0] name_length,
  input wire logic       end_of_name,
  input wire logic       run_last
);

  // stalled transaction holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(end_of_name)
      && $stable(name_length) && $stable(run_last))
    else $error("stalled output transaction changed");

  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (byte_valid != end_of_name))
    else $error("result is neither a byte nor a length");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_name |-> run_last && (out_byte == 8'd0))
    else $error("length result not last or carries a byte");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_valid |-> (name_length == 8'd0))
    else $error("byte result carries a length");

endmodule

bind iso9660_name_translate_top isont_checker u_isont_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (name_out.valid),
  .out_ready   (name_out.ready),
  .out_byte    (name_out.out_byte),
  .byte_valid  (name_out.byte_valid),
  .name_length (name_out.name_length),
  .end_of_name (name_out.end_of_name),
  .run_last    (name_out.run_last)
);

`default_nettype wire
